/* rtl/crz_pkg.sv */
// Shared constants and codes for the circle rasterizer.
`default_nettype none
package crz_pkg;

  // Default field widths
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int RADIUS_WIDTH_DEF = 12;

  // Iteration queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input operation codes (carried on in_tuser)
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes
  localparam int REG_FILL_MODE = 0;

endpackage
`default_nettype wire

/* rtl/crz_queue.sv */
// Short show-ahead queue of iteration descriptors.
`default_nettype none
module crz_queue
  import crz_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/crz_front.sv */
// Front end: takes start/step beats, runs the decision rule, queues iterations.
`default_nettype none
module crz_front
  import crz_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fill_mode,
  // input beat
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic [RADIUS_WIDTH-1:0]       in_radius,
  // iteration descriptor to the queue
  output logic                          it_valid,
  input  logic                          it_ready,
  output logic signed [COORD_WIDTH-1:0] it_cx,
  output logic signed [COORD_WIDTH-1:0] it_cy,
  output logic signed [RADIUS_WIDTH:0]  it_a,
  output logic signed [RADIUS_WIDTH:0]  it_c,
  output logic                          it_fill,
  output logic                          it_done
);

  localparam int OFF_W = RADIUS_WIDTH + 1;
  localparam int DEC_W = RADIUS_WIDTH + 2;
  localparam int EW    = RADIUS_WIDTH + 4;

  logic signed [COORD_WIDTH-1:0] cx_r, cy_r;
  logic [RADIUS_WIDTH-1:0]       rad_r;
  logic signed [OFF_W-1:0]       a_r, c_r;
  logic signed [DEC_W-1:0]       d_r;
  logic                          active_r;

  logic                          start, accept, cur_active;
  logic [RADIUS_WIDTH-1:0]       cur_r;
  logic signed [OFF_W-1:0]       cur_a, cur_c, new_a, new_c;
  logic signed [DEC_W-1:0]       cur_d, new_d;
  logic signed [EW-1:0]          ea, ec, ed, er, nd;
  logic                          done;

  assign in_ready = it_ready;
  assign accept   = in_valid && in_ready;
  assign start    = (in_op == OP_START);

  // Working values: a start beat replaces the saved circle
  always_comb begin
    cur_r      = start ? in_radius : rad_r;
    cur_a      = start ? '0 : a_r;
    cur_c      = start ? signed'({1'b0, in_radius}) : c_r;
    cur_d      = start ? signed'(DEC_W'(in_radius) - DEC_W'(1)) : d_r;
    cur_active = start || active_r;
  end

  // Decision rule on sign-extended operands
  always_comb begin
    ea    = EW'(cur_a);
    ec    = EW'(cur_c);
    ed    = EW'(cur_d);
    er    = signed'(EW'(cur_r));
    nd    = ed;
    new_a = cur_a;
    new_c = cur_c;
    if (ed >= ea + ea) begin
      nd    = ed - (ea + ea) - EW'(1);
      new_a = cur_a + OFF_W'(1);
    end else if (ed < (er - ec) + (er - ec)) begin
      nd    = ed + ec + ec - EW'(1);
      new_c = cur_c - OFF_W'(1);
    end else begin
      nd    = ed + (ec - ea - EW'(1)) + (ec - ea - EW'(1));
      new_c = cur_c - OFF_W'(1);
      new_a = cur_a + OFF_W'(1);
    end
    new_d = nd[DEC_W-1:0];
    done  = (new_c < new_a);
  end

  // Descriptor of the iteration being emitted
  assign it_valid = accept && cur_active;
  assign it_cx    = start ? in_center_x : cx_r;
  assign it_cy    = start ? in_center_y : cy_r;
  assign it_a     = cur_a;
  assign it_c     = cur_c;
  assign it_fill  = fill_mode;
  assign it_done  = done;

  // Circle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      rad_r    <= '0;
      a_r      <= '0;
      c_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      if (start) begin
        cx_r  <= in_center_x;
        cy_r  <= in_center_y;
        rad_r <= in_radius;
      end
      if (cur_active) begin
        a_r      <= new_a;
        c_r      <= new_c;
        d_r      <= new_d;
        active_r <= !done;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/crz_back.sv */
// Back end: expands one queued iteration into point or span beats.
`default_nettype none
module crz_back
  import crz_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // queue head
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic signed [COORD_WIDTH-1:0] q_cx,
  input  logic signed [COORD_WIDTH-1:0] q_cy,
  input  logic signed [RADIUS_WIDTH:0]  q_a,
  input  logic signed [RADIUS_WIDTH:0]  q_c,
  input  logic                          q_fill,
  input  logic                          q_done,
  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_x_start,
  output logic [COORD_WIDTH-1:0]        out_x_end,
  output logic [COORD_WIDTH-1:0]        out_y_pos,
  output logic                          out_last,
  output logic                          out_done
);

  localparam int OFF_W = RADIUS_WIDTH + 1;
  localparam int EXT_W = COORD_WIDTH + OFF_W;

  logic [2:0]             beat_r;
  logic                   out_valid_r, out_last_r, out_done_r;
  logic [COORD_WIDTH-1:0] xs_r, xe_r, y_r;

  logic                   load, last_beat;
  logic [EXT_W-1:0]       a_ext, c_ext;
  logic [COORD_WIDTH-1:0] a_w, c_w;
  logic [COORD_WIDTH-1:0] xpa, xma, xpc, xmc, ypa, yma, ypc, ymc;
  logic [COORD_WIDTH-1:0] xs_nxt, xe_nxt, y_nxt;

  // Offsets wrapped to coordinate width
  assign a_ext = EXT_W'(q_a);
  assign c_ext = EXT_W'(q_c);
  assign a_w   = a_ext[COORD_WIDTH-1:0];
  assign c_w   = c_ext[COORD_WIDTH-1:0];

  assign xpa = q_cx + a_w;
  assign xma = q_cx - a_w;
  assign xpc = q_cx + c_w;
  assign xmc = q_cx - c_w;
  assign ypa = q_cy + a_w;
  assign yma = q_cy - a_w;
  assign ypc = q_cy + c_w;
  assign ymc = q_cy - c_w;

  // Beat select: four spans or eight points
  always_comb begin
    xs_nxt = xpa;
    xe_nxt = xpa;
    y_nxt  = ypc;
    if (q_fill) begin
      unique case (beat_r)
        3'd0: begin xs_nxt = xmc; xe_nxt = xpc; y_nxt = ypa; end
        3'd1: begin xs_nxt = xma; xe_nxt = xpa; y_nxt = ypc; end
        3'd2: begin xs_nxt = xma; xe_nxt = xpa; y_nxt = ymc; end
        default: begin xs_nxt = xmc; xe_nxt = xpc; y_nxt = yma; end
      endcase
    end else begin
      unique case (beat_r)
        3'd0: begin xs_nxt = xpa; y_nxt = ypc; end
        3'd1: begin xs_nxt = xpc; y_nxt = ypa; end
        3'd2: begin xs_nxt = xma; y_nxt = ypc; end
        3'd3: begin xs_nxt = xmc; y_nxt = ypa; end
        3'd4: begin xs_nxt = xpa; y_nxt = ymc; end
        3'd5: begin xs_nxt = xpc; y_nxt = yma; end
        3'd6: begin xs_nxt = xma; y_nxt = ymc; end
        3'd7: begin xs_nxt = xmc; y_nxt = yma; end
      endcase
      xe_nxt = xs_nxt;
    end
  end

  assign last_beat = q_fill ? (beat_r == 3'd3) : (beat_r == 3'd7);
  assign load      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = load && last_beat;

  // Beat counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      if (load) begin
        beat_r      <= last_beat ? 3'd0 : beat_r + 3'd1;
        out_valid_r <= 1'b1;
        out_last_r  <= last_beat;
        out_done_r  <= last_beat && q_done;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      xs_r <= xs_nxt;
      xe_r <= xe_nxt;
      y_r  <= y_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x_start = xs_r;
  assign out_x_end   = xe_r;
  assign out_y_pos   = y_r;
  assign out_last    = out_last_r;
  assign out_done    = out_done_r;

  // Mid-iteration the descriptor must still sit at the queue head
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r != 3'd0) |-> q_valid)
    else $error("beat counter running with empty queue");

  // Circle completion only marks the last beat of an iteration
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("circle_done without last_of_run");

  // Span iterations stop after four beats
  a_fill_four: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_fill) |-> !beat_r[2])
    else $error("fill iteration beyond fourth span");

  // Popping the head only happens on a loaded last beat
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_last_r))
    else $error("queue pop without last beat");

endmodule
`default_nettype wire

/* rtl/circle_rasterizer_top.sv */
// Circle rasterizer top level: stream ports, config register, front/queue/back.
//
// Midpoint-circle rasterizer. A start beat (tuser = 0) loads centre and radius and
// emits the first iteration; each step beat (tuser = 1) emits the next one. An
// iteration gives eight outline points (x_start == x_end) or, with fill_mode set,
// four horizontal spans; tlast marks the last beat of an iteration and tuser on
// the result side marks the last beat of the circle. The front end takes one
// input beat per cycle while the two-entry iteration queue has room; the result
// channel then delivers one beat per cycle while out_tready is high, so a step
// gives eight beats in outline mode and four in fill mode at the output. Steps
// with no circle running are accepted and give no result. Coordinates wrap at
// COORD_WIDTH bits. Write fill_mode only while the block is idle.
`default_nettype none
module circle_rasterizer_top
  import crz_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF,
  localparam int IN_DW  = ((2 * COORD_WIDTH + RADIUS_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // center_x, center_y, radius, zero pad
  input  logic              in_tuser,   // op
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // x_start, x_end, y_pos, zero pad
  output logic              out_tlast,  // last_of_run
  output logic              out_tuser,  // circle_done
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int OFF_W = RADIUS_WIDTH + 1;
  localparam int Q_W   = 2 * COORD_WIDTH + 2 * OFF_W + 2;

  logic                          fill_mode_r;
  logic                          cfg_wr, cfg_sel_fill;

  logic                          it_valid, it_ready, it_fill, it_done;
  logic signed [COORD_WIDTH-1:0] it_cx, it_cy;
  logic signed [OFF_W-1:0]       it_a, it_c;
  logic [Q_W-1:0]                q_in, q_out;
  logic                          q_valid, q_pop;

  logic [COORD_WIDTH-1:0]        xs, xe, yp;

  // Configuration register
  assign cfg_pready   = 1'b1;
  assign cfg_sel_fill = (cfg_paddr == 3'(4 * REG_FILL_MODE));
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata   = cfg_sel_fill ? {31'd0, fill_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_mode_r <= 1'b0;
    end else if (cfg_wr && cfg_sel_fill) begin
      fill_mode_r <= cfg_pwdata[0];
    end
  end

  // Front end
  crz_front #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .fill_mode   (fill_mode_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_center_x (in_tdata[COORD_WIDTH-1:0]),
    .in_center_y (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_radius   (in_tdata[2*COORD_WIDTH+RADIUS_WIDTH-1:2*COORD_WIDTH]),
    .it_valid    (it_valid),
    .it_ready    (it_ready),
    .it_cx       (it_cx),
    .it_cy       (it_cy),
    .it_a        (it_a),
    .it_c        (it_c),
    .it_fill     (it_fill),
    .it_done     (it_done)
  );

  // Iteration queue
  assign q_in = {it_done, it_fill, it_c, it_a, it_cy, it_cx};

  crz_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (it_valid),
    .push_ready (it_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_out)
  );

  // Back end
  crz_back #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cx        (q_out[COORD_WIDTH-1:0]),
    .q_cy        (q_out[2*COORD_WIDTH-1:COORD_WIDTH]),
    .q_a         (q_out[2*COORD_WIDTH+OFF_W-1:2*COORD_WIDTH]),
    .q_c         (q_out[2*COORD_WIDTH+2*OFF_W-1:2*COORD_WIDTH+OFF_W]),
    .q_fill      (q_out[Q_W-2]),
    .q_done      (q_out[Q_W-1]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_x_start (xs),
    .out_x_end   (xe),
    .out_y_pos   (yp),
    .out_last    (out_tlast),
    .out_done    (out_tuser)
  );

  assign out_tdata = OUT_DW'({yp, xe, xs});

endmodule
`default_nettype wire
